### rtl/rddf_pkg.sv
// Shared types and constants for the dawn/dusk LED fader.
// Command and register codes, sequencer ops, fixed-point constants.
// No dependencies.
`default_nettype none

package rddf_pkg;

  localparam int unsigned UPDATE_INTERVAL_MS = 20;
  localparam int unsigned PWM_BITS           = 12;

  localparam int unsigned LVL_W = 12;
  localparam int unsigned MS_W  = 26;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CFG_W = 26;
  localparam int unsigned NUM_CH = 3;

  localparam logic [LVL_W-1:0] LEVEL_CAP =
      (PWM_BITS >= LVL_W) ? {LVL_W{1'b1}} : LVL_W'((1 << PWM_BITS) - 1);
  localparam logic [15:0] UPD_INTERVAL = 16'(UPDATE_INTERVAL_MS);

  // Divider produces a Q16 progress value, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

  localparam logic [1:0] CH_WHITE = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Q16 fixed-point constants
  localparam logic [16:0] Q16_ONE   = 17'h10000;
  localparam logic [17:0] Q16_THREE = 18'd196608;
  localparam logic [18:0] P5_ONE    = 19'd65536;
  localparam logic [18:0] P5_TWO    = 19'd131072;
  localparam logic [18:0] P5_THREE  = 19'd196608;
  localparam logic [18:0] P5_FOUR   = 19'd262144;

  // Reciprocals: x/3 = (x*RECIP3)>>19 for x<2^18, x/100 = (x*RECIP100)>>26 for x<2^19
  localparam logic [19:0] RECIP3   = 20'd174763;
  localparam logic [19:0] RECIP100 = 20'd671089;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [LVL_W-1:0] MAX_WHITE_RST  = 12'd3000;
  localparam logic [LVL_W-1:0] MAX_RED_RST    = 12'd2500;
  localparam logic [LVL_W-1:0] MAX_BLUE_RST   = 12'd2000;
  localparam logic [MS_W-1:0]  SUNRISE_MS_RST = 26'd30000;
  localparam logic [MS_W-1:0]  SUNSET_MS_RST  = 26'd45000;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_LEVELS = 3'd1,
    CMD_SUNRISE    = 3'd2,
    CMD_SUNSET     = 3'd3,
    CMD_STOP       = 3'd4,
    CMD_OFF        = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_MAX_WHITE  = 3'd0,
    CFG_MAX_RED    = 3'd1,
    CFG_MAX_BLUE   = 3'd2,
    CFG_SUNRISE_MS = 3'd3,
    CFG_SUNSET_MS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_DIV,
    OP_RAMP,
    OP_SQ,
    OP_CUBE,
    OP_LVL,
    OP_WB,
    OP_PCT,
    OP_PCTDIV,
    OP_PCTWB,
    OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RAMP,
    ST_SQ,
    ST_CUBE,
    ST_LVL,
    ST_WB,
    ST_PCT,
    ST_PCTDIV,
    ST_PCTWB,
    ST_FIN
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] ch;
  } dp_ctl_t;

  typedef struct packed {
    logic go_div;
    logic go_set;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/rddf_ctrl.sv
// Sequencer state machine for the fader: steps the datapath through
// command execution, progress division and per-channel easing.
// Depends on rddf_pkg.
`default_nettype none

module rddf_ctrl
  import rddf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output dp_ctl_t      ctl_o
);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin : next_state
    state_d = state_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cnt_d = '0;
        ch_d  = CH_WHITE;
        priority if (sts_i.go_div) state_d = ST_DIV;
        else if (sts_i.go_set)     state_d = ST_PCT;
        else                       state_d = ST_FIN;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DIV_LAST) state_d = ST_RAMP;
      end
      ST_RAMP: state_d = ST_SQ;
      ST_SQ:   state_d = ST_CUBE;
      ST_CUBE: state_d = ST_LVL;
      ST_LVL:  state_d = ST_WB;
      ST_WB: begin
        if (ch_q == CH_BLUE) begin
          state_d = ST_FIN;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_RAMP;
        end
      end
      ST_PCT:    state_d = ST_PCTDIV;
      ST_PCTDIV: state_d = ST_PCTWB;
      ST_PCTWB: begin
        if (ch_q == CH_BLUE) begin
          state_d = ST_FIN;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_PCT;
        end
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin : outputs
    ctl_o.ch    = ch_q;
    ctl_o.op    = OP_NONE;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE:   ctl_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_EXEC:   ctl_o.op = OP_EXEC;
      ST_DIV:    ctl_o.op = OP_DIV;
      ST_RAMP:   ctl_o.op = OP_RAMP;
      ST_SQ:     ctl_o.op = OP_SQ;
      ST_CUBE:   ctl_o.op = OP_CUBE;
      ST_LVL:    ctl_o.op = OP_LVL;
      ST_WB:     ctl_o.op = OP_WB;
      ST_PCT:    ctl_o.op = OP_PCT;
      ST_PCTDIV: ctl_o.op = OP_PCTDIV;
      ST_PCTWB:  ctl_o.op = OP_PCTWB;
      ST_FIN: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctl_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default:   ctl_o.op = OP_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ch_q        <= CH_WHITE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rddf_dp.sv
// Datapath of the fader: config and fade state, bit-serial progress divider,
// one shared 20x20 multiplier for ramps, easing and level scaling.
// Depends on rddf_pkg; driven by rddf_ctrl.
`default_nettype none

module rddf_dp
  import rddf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_ctl_t          ctl_i,
  output dp_sts_t               sts_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic [2:0]       cmd_i,
  input  wire logic [PCT_W-1:0] white_pct_i,
  input  wire logic [PCT_W-1:0] red_pct_i,
  input  wire logic [PCT_W-1:0] blue_pct_i,
  output logic [LVL_W-1:0]      pwm_white_o,
  output logic [LVL_W-1:0]      pwm_red_o,
  output logic [LVL_W-1:0]      pwm_blue_o,
  output logic                  fading_o,
  output logic                  accepted_o,
  output logic                  finished_o,
  output logic                  finished_sunrise_o,
  output logic [MS_W-1:0]       remaining_ms_o
);

  typedef enum logic [2:0] {
    RAMP_ZERO,
    RAMP_ONE,
    RAMP_PASS,
    RAMP_DIV2,
    RAMP_DIV3
  } ramp_e;

  // configuration
  logic [LVL_W-1:0] max_q [NUM_CH];
  logic [LVL_W-1:0] max_d [NUM_CH];
  logic [MS_W-1:0]  rise_ms_q, rise_ms_d, set_ms_q, set_ms_d;

  // fade state
  logic [LVL_W-1:0] tgt_q [NUM_CH];
  logic [LVL_W-1:0] tgt_d [NUM_CH];
  logic [LVL_W-1:0] cur_q [NUM_CH];
  logic [LVL_W-1:0] cur_d [NUM_CH];
  logic [LVL_W-1:0] start_q [NUM_CH];
  logic [LVL_W-1:0] start_d [NUM_CH];
  logic             active_q, active_d, rise_q, rise_d, upd_once_q, upd_once_d;
  logic [MS_W-1:0]  elapsed_q, elapsed_d;
  logic [15:0]      since_q, since_d;
  logic             acc_q, acc_d, fin_q, fin_d, finrise_q, finrise_d;

  // item and working registers
  logic [2:0]       cmd_q;
  logic [PCT_W-1:0] pct_q [NUM_CH];
  logic [MS_W-1:0]  rem_q;
  logic [15:0]      quo_q;
  logic [17:0]      x_q;
  ramp_e            kind_q;
  logic [16:0]      t_q;
  logic [39:0]      prod_q;

  // result register
  logic [LVL_W-1:0] pwm_q [NUM_CH];
  logic             fading_q, acc_out_q, fin_out_q, finrise_out_q;
  logic [MS_W-1:0]  remain_q;

  logic [MS_W-1:0]  dur, elap_inc;
  logic [15:0]      since_inc;
  logic             upd, done;
  logic [MS_W:0]    rem_sh;
  logic             div_ge;
  logic [18:0]      p5;
  logic [17:0]      ramp_x;
  ramp_e            ramp_kind;
  logic [16:0]      t_sel, lvl_e, lvl_f;
  logic [17:0]      cube_b;
  logic [LVL_W-1:0] lvl_base;
  logic [PCT_W-1:0] pct_c;
  logic [19:0]      mul_a, mul_b;
  logic [39:0]      mul_p;
  logic             mul_en;
  logic [MS_W-1:0]  remain;
  logic [LVL_W-1:0] cap [NUM_CH];
  logic [LVL_W-1:0] pwm_v [NUM_CH];

  assign dur       = rise_q ? rise_ms_q : set_ms_q;
  assign elap_inc  = (elapsed_q == {MS_W{1'b1}}) ? elapsed_q : elapsed_q + 26'd1;
  assign since_inc = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
  assign upd       = !upd_once_q || (since_inc >= UPD_INTERVAL);
  assign done      = elap_inc >= dur;

  assign sts_o.go_div = (cmd_q == CMD_TICK) && active_q && upd && !done;
  assign sts_o.go_set = (cmd_q == CMD_SET_LEVELS);

  // Restoring divider step: remainder stays below the duration
  assign rem_sh = {rem_q, 1'b0};
  assign div_ge = rem_sh >= {1'b0, dur};

  // Staggered ramp per channel, numerator and shape
  assign p5 = {1'b0, quo_q, 2'b00} + {3'b000, quo_q};

  always_comb begin : ramp_select
    ramp_x    = '0;
    ramp_kind = RAMP_ZERO;
    unique case (ctl_i.ch)
      CH_WHITE: begin
        if (p5 <= P5_ONE) begin
          ramp_kind = RAMP_ZERO;
        end else if (p5 <= P5_FOUR) begin
          ramp_kind = RAMP_DIV3;
          ramp_x    = 18'(p5 - P5_ONE);
        end else begin
          ramp_kind = RAMP_ONE;
        end
      end
      CH_RED: begin
        if (rise_q) begin
          ramp_kind = RAMP_PASS;
          ramp_x    = {2'b00, quo_q};
        end else if (p5 <= P5_TWO) begin
          ramp_kind = RAMP_ZERO;
        end else begin
          ramp_kind = RAMP_DIV3;
          ramp_x    = 18'(p5 - P5_TWO);
        end
      end
      default: begin
        if (rise_q) begin
          if (p5 <= P5_THREE) begin
            ramp_kind = RAMP_ZERO;
          end else begin
            ramp_kind = RAMP_DIV2;
            ramp_x    = 18'(p5 - P5_THREE);
          end
        end else if (p5 <= P5_THREE) begin
          ramp_kind = RAMP_DIV3;
          ramp_x    = 18'(p5);
        end else begin
          ramp_kind = RAMP_ONE;
        end
      end
    endcase
  end

  always_comb begin : t_select
    unique case (kind_q)
      RAMP_ZERO: t_sel = '0;
      RAMP_ONE:  t_sel = Q16_ONE;
      RAMP_PASS: t_sel = x_q[16:0];
      RAMP_DIV2: t_sel = x_q[17:1];
      RAMP_DIV3: t_sel = prod_q[35:19];
      default:   t_sel = '0;
    endcase
  end

  assign cube_b   = Q16_THREE - {t_q, 1'b0};
  assign lvl_e    = prod_q[32:16];
  assign lvl_f    = rise_q ? lvl_e : Q16_ONE - lvl_e;
  assign lvl_base = rise_q ? tgt_q[ctl_i.ch] : start_q[ctl_i.ch];
  assign pct_c    = (pct_q[ctl_i.ch] > PCT_MAX) ? PCT_MAX : pct_q[ctl_i.ch];

  // Shared multiplier operand select
  always_comb begin : mul_select
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (ctl_i.op)
      OP_RAMP: begin
        mul_a = {2'b00, ramp_x};
        mul_b = RECIP3;
      end
      OP_SQ: begin
        mul_a = {3'b000, t_sel};
        mul_b = {3'b000, t_sel};
      end
      OP_CUBE: begin
        mul_a = {3'b000, prod_q[32:16]};
        mul_b = {2'b00, cube_b};
      end
      OP_LVL: begin
        mul_a = {8'd0, lvl_base};
        mul_b = {3'b000, lvl_f};
      end
      OP_PCT: begin
        mul_a = {13'd0, pct_c};
        mul_b = {8'd0, max_q[ctl_i.ch]};
      end
      OP_PCTDIV: begin
        mul_a = {1'b0, prod_q[18:0]};
        mul_b = RECIP100;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = {20'd0, mul_a} * {20'd0, mul_b};

  always_comb begin : state_next
    max_d      = max_q;
    rise_ms_d  = rise_ms_q;
    set_ms_d   = set_ms_q;
    tgt_d      = tgt_q;
    cur_d      = cur_q;
    start_d    = start_q;
    active_d   = active_q;
    rise_d     = rise_q;
    upd_once_d = upd_once_q;
    elapsed_d  = elapsed_q;
    since_d    = since_q;
    acc_d      = acc_q;
    fin_d      = fin_q;
    finrise_d  = finrise_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_WHITE:  max_d[0]  = cfg_wdata_i[LVL_W-1:0];
        CFG_MAX_RED:    max_d[1]  = cfg_wdata_i[LVL_W-1:0];
        CFG_MAX_BLUE:   max_d[2]  = cfg_wdata_i[LVL_W-1:0];
        CFG_SUNRISE_MS: rise_ms_d = cfg_wdata_i;
        CFG_SUNSET_MS:  set_ms_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (ctl_i.op)
      OP_LOAD: begin
        acc_d     = 1'b0;
        fin_d     = 1'b0;
        finrise_d = 1'b0;
      end
      OP_EXEC: begin
        unique case (cmd_q)
          CMD_TICK: begin
            if (active_q) begin
              elapsed_d = elap_inc;
              since_d   = since_inc;
              if (upd) begin
                since_d    = '0;
                upd_once_d = 1'b1;
                if (done) begin
                  cur_d     = tgt_q;
                  active_d  = 1'b0;
                  fin_d     = 1'b1;
                  finrise_d = rise_q;
                end
              end
            end
          end
          CMD_SUNRISE: begin
            if (!active_q) begin
              for (int i = 0; i < NUM_CH; i++) begin
                start_d[i] = '0;
                cur_d[i]   = '0;
              end
              active_d   = 1'b1;
              rise_d     = 1'b1;
              elapsed_d  = '0;
              since_d    = '0;
              upd_once_d = 1'b0;
              acc_d      = 1'b1;
            end
          end
          CMD_SUNSET: begin
            if (!active_q) begin
              for (int i = 0; i < NUM_CH; i++) begin
                start_d[i] = cur_q[i];
                tgt_d[i]   = '0;
              end
              active_d   = 1'b1;
              rise_d     = 1'b0;
              elapsed_d  = '0;
              since_d    = '0;
              upd_once_d = 1'b0;
              acc_d      = 1'b1;
            end
          end
          CMD_STOP: active_d = 1'b0;
          CMD_OFF: begin
            active_d = 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
              tgt_d[i] = '0;
              cur_d[i] = '0;
            end
          end
          default: ;
        endcase
      end
      OP_WB: cur_d[ctl_i.ch] = prod_q[27:16];
      OP_PCTWB: begin
        tgt_d[ctl_i.ch] = prod_q[37:26];
        if (!active_q) cur_d[ctl_i.ch] = prod_q[37:26];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q[0]   <= MAX_WHITE_RST;
      max_q[1]   <= MAX_RED_RST;
      max_q[2]   <= MAX_BLUE_RST;
      rise_ms_q  <= SUNRISE_MS_RST;
      set_ms_q   <= SUNSET_MS_RST;
      for (int i = 0; i < NUM_CH; i++) begin
        tgt_q[i]   <= '0;
        cur_q[i]   <= '0;
        start_q[i] <= '0;
      end
      active_q   <= 1'b0;
      rise_q     <= 1'b0;
      upd_once_q <= 1'b0;
      elapsed_q  <= '0;
      since_q    <= '0;
      acc_q      <= 1'b0;
      fin_q      <= 1'b0;
      finrise_q  <= 1'b0;
    end else begin
      max_q      <= max_d;
      rise_ms_q  <= rise_ms_d;
      set_ms_q   <= set_ms_d;
      tgt_q      <= tgt_d;
      cur_q      <= cur_d;
      start_q    <= start_d;
      active_q   <= active_d;
      rise_q     <= rise_d;
      upd_once_q <= upd_once_d;
      elapsed_q  <= elapsed_d;
      since_q    <= since_d;
      acc_q      <= acc_d;
      fin_q      <= fin_d;
      finrise_q  <= finrise_d;
    end
  end

  // Result values
  assign remain = (active_q && (elapsed_q < dur)) ? dur - elapsed_q : '0;

  always_comb begin : clamp
    for (int i = 0; i < NUM_CH; i++) begin
      cap[i]   = (max_q[i] > LEVEL_CAP) ? LEVEL_CAP : max_q[i];
      pwm_v[i] = (cur_q[i] > cap[i]) ? cap[i] : cur_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LOAD) begin
      cmd_q    <= cmd_i;
      pct_q[0] <= white_pct_i;
      pct_q[1] <= red_pct_i;
      pct_q[2] <= blue_pct_i;
    end
    if (ctl_i.op == OP_EXEC) begin
      rem_q <= elap_inc;
      quo_q <= '0;
    end
    if (ctl_i.op == OP_DIV) begin
      rem_q <= div_ge ? MS_W'(rem_sh - {1'b0, dur}) : rem_sh[MS_W-1:0];
      quo_q <= {quo_q[14:0], div_ge};
    end
    if (ctl_i.op == OP_RAMP) begin
      x_q    <= ramp_x;
      kind_q <= ramp_kind;
    end
    if (ctl_i.op == OP_SQ) t_q <= t_sel;
    if (mul_en) prod_q <= mul_p;
    if (ctl_i.op == OP_OUT) begin
      pwm_q         <= pwm_v;
      fading_q      <= active_q;
      acc_out_q     <= acc_q;
      fin_out_q     <= fin_q;
      finrise_out_q <= finrise_q;
      remain_q      <= remain;
    end
  end

  assign pwm_white_o        = pwm_q[0];
  assign pwm_red_o          = pwm_q[1];
  assign pwm_blue_o         = pwm_q[2];
  assign fading_o           = fading_q;
  assign accepted_o         = acc_out_q;
  assign finished_o         = fin_out_q;
  assign finished_sunrise_o = finrise_out_q;
  assign remaining_ms_o     = remain_q;

endmodule

`default_nettype wire

### rtl/rgb_dawn_dusk_fader.sv
// Top level of the three-channel dawn/dusk LED fader.
// Joins the sequencer (rddf_ctrl) and the datapath (rddf_dp); uses rddf_pkg.
//
//   Port group   Direction  Handshake                Payload
//   in           input      in_valid_i / in_stall_o  cmd_i, white/red/blue_pct_i
//   out          output     out_valid_o / out_stall_i pwm_*_o, fading_o, accepted_o,
//                                                    finished_o, finished_sunrise_o,
//                                                    remaining_ms_o
//   cfg          input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One item at a time. A tick that recomputes levels executes, runs the bit-serial
// progress divider, takes each channel through ramp, square, cube, level and
// write-back on the shared multiplier, then loads the result. Set levels scales each
// channel by its percentage; other commands just execute. Input frees after the load.
// Reset clears all levels and loads the default maxima and durations. The next item
// is taken while a result waits under out_stall_i; its result holds until then.
`default_nettype none

module rgb_dawn_dusk_fader
  import rddf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [2:0]       cmd_i,
  input  wire logic [PCT_W-1:0] white_pct_i,
  input  wire logic [PCT_W-1:0] red_pct_i,
  input  wire logic [PCT_W-1:0] blue_pct_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [LVL_W-1:0]      pwm_white_o,
  output logic [LVL_W-1:0]      pwm_red_o,
  output logic [LVL_W-1:0]      pwm_blue_o,
  output logic                  fading_o,
  output logic                  accepted_o,
  output logic                  finished_o,
  output logic                  finished_sunrise_o,
  output logic [MS_W-1:0]       remaining_ms_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  rddf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rddf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd_i),
    .white_pct_i        (white_pct_i),
    .red_pct_i          (red_pct_i),
    .blue_pct_i         (blue_pct_i),
    .pwm_white_o        (pwm_white_o),
    .pwm_red_o          (pwm_red_o),
    .pwm_blue_o         (pwm_blue_o),
    .fading_o           (fading_o),
    .accepted_o         (accepted_o),
    .finished_o         (finished_o),
    .finished_sunrise_o (finished_sunrise_o),
    .remaining_ms_o     (remaining_ms_o)
  );

  // A completed fade is no longer running
  a_fin_not_fading : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> !fading_o)
    else $error("finished result still reports fading");

  a_idle_no_remaining : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fading_o |-> remaining_ms_o == '0)
    else $error("remaining time nonzero while idle");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> fading_o && !finished_o)
    else $error("accepted start did not leave a fade running");

  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the item was processed");

endmodule

`default_nettype wire

### verif/tb_rgb_dawn_dusk_fader.sv
// Self-checking testbench for rgb_dawn_dusk_fader: a fade sequencer predictor in the
// bench tracks levels, progress and completion and checks every output transfer.
// Depends on rddf_pkg and the RTL top level only.
module tb_rgb_dawn_dusk_fader;
  import rddf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_COUNT  = 1050;
  localparam longint unsigned Q1 = 65536;
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'(CMD_OFF) + 3'd1;
  localparam logic [2:0] CFG_UNUSED_LO  = 3'(CFG_SUNSET_MS) + 3'd1;

  typedef struct packed {
    logic [2:0]       op;
    logic [PCT_W-1:0] white;
    logic [PCT_W-1:0] red;
    logic [PCT_W-1:0] blue;
  } fader_cmd_t;

  typedef struct packed {
    logic [NUM_CH-1:0][LVL_W-1:0] pwm;
    logic                         fading;
    logic                         accepted;
    logic                         finished;
    logic                         finished_sunrise;
    logic [MS_W-1:0]              remaining;
  } fader_out_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [2:0]       cmd_i = '0;
  logic [PCT_W-1:0] white_pct_i = '0;
  logic [PCT_W-1:0] red_pct_i = '0;
  logic [PCT_W-1:0] blue_pct_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [LVL_W-1:0] pwm_white_o;
  logic [LVL_W-1:0] pwm_red_o;
  logic [LVL_W-1:0] pwm_blue_o;
  logic             fading_o;
  logic             accepted_o;
  logic             finished_o;
  logic             finished_sunrise_o;
  logic [MS_W-1:0]  remaining_ms_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  rgb_dawn_dusk_fader i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .white_pct_i        (white_pct_i),
    .red_pct_i          (red_pct_i),
    .blue_pct_i         (blue_pct_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pwm_white_o        (pwm_white_o),
    .pwm_red_o          (pwm_red_o),
    .pwm_blue_o         (pwm_blue_o),
    .fading_o           (fading_o),
    .accepted_o         (accepted_o),
    .finished_o         (finished_o),
    .finished_sunrise_o (finished_sunrise_o),
    .remaining_ms_o     (remaining_ms_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Fader state as the bench sees it
  logic [LVL_W-1:0] full_scale [NUM_CH] = '{MAX_WHITE_RST, MAX_RED_RST, MAX_BLUE_RST};
  logic [MS_W-1:0]  rise_ms = SUNRISE_MS_RST;
  logic [MS_W-1:0]  fall_ms = SUNSET_MS_RST;
  logic [LVL_W-1:0] goal [NUM_CH] = '{default: '0};
  logic [LVL_W-1:0] level [NUM_CH] = '{default: '0};
  logic [LVL_W-1:0] origin [NUM_CH] = '{default: '0};
  bit               running = 1'b0;
  bit               rising = 1'b0;
  bit               refreshed = 1'b0;
  logic [MS_W-1:0]  elapsed = '0;
  logic [15:0]      since_refresh = '0;

  fader_cmd_t  cmds_pending [$];
  fader_out_t  levels_due [$];
  fader_cmd_t  next_cmd;
  fader_out_t  due;
  int unsigned items_made = 0;
  int unsigned outstanding = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  bit          in_taken = 1'b0;
  bit          calm = 1'b0;
  bit          failed = 1'b0;

  function automatic longint unsigned smooth(input longint unsigned t);
    longint unsigned sq;
    sq = (t * t) >> 16;
    return (sq * (3 * Q1 - 2 * t)) >> 16;
  endfunction

  // Recompute all three levels from progress; returns 1 once the fade is over
  function automatic bit refresh_levels();
    longint unsigned dur, p, p5;
    longint unsigned ramp [NUM_CH];
    int ch;
    dur = 64'(rising ? rise_ms : fall_ms);
    if (64'(elapsed) >= dur) begin
      for (ch = 0; ch < NUM_CH; ch++) level[ch] = goal[ch];
      return 1'b1;
    end
    p = 64'(elapsed);
    p = (p << 16) / dur;
    p5 = 5 * p;
    ramp[CH_WHITE] = (p5 <= Q1) ? 0 : ((p5 <= 4 * Q1) ? (p5 - Q1) / 3 : Q1);
    if (rising) begin
      ramp[CH_RED]  = p;
      ramp[CH_BLUE] = (p5 <= 3 * Q1) ? 0 : (p5 - 3 * Q1) / 2;
      for (ch = 0; ch < NUM_CH; ch++)
        level[ch] = LVL_W'((64'(goal[ch]) * smooth(ramp[ch])) >> 16);
    end else begin
      ramp[CH_RED]  = (p5 <= 2 * Q1) ? 0 : (p5 - 2 * Q1) / 3;
      ramp[CH_BLUE] = (p5 <= 3 * Q1) ? p5 / 3 : Q1;
      for (ch = 0; ch < NUM_CH; ch++)
        level[ch] = LVL_W'((64'(origin[ch]) * (Q1 - smooth(ramp[ch]))) >> 16);
    end
    return 1'b0;
  endfunction

  function automatic fader_out_t step_fader(input fader_cmd_t c);
    fader_out_t       r;
    logic [PCT_W-1:0] pct [NUM_CH];
    longint unsigned  v, dur, cap;
    int               ch;
    r = '0;
    pct[CH_WHITE] = c.white;
    pct[CH_RED]   = c.red;
    pct[CH_BLUE]  = c.blue;
    case (c.op)
      CMD_TICK: begin
        if (running) begin
          if (elapsed != {MS_W{1'b1}}) elapsed++;
          if (since_refresh != 16'hFFFF) since_refresh++;
          if (!refreshed || since_refresh >= UPD_INTERVAL) begin
            since_refresh = '0;
            refreshed = 1'b1;
            if (refresh_levels()) begin
              running = 1'b0;
              r.finished = 1'b1;
              r.finished_sunrise = rising;
            end
          end
        end
      end
      CMD_SET_LEVELS: begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          v = 64'((pct[ch] > PCT_MAX) ? PCT_MAX : pct[ch]);
          goal[ch] = LVL_W'(v * 64'(full_scale[ch]) / 64'(PCT_MAX));
          if (!running) level[ch] = goal[ch];
        end
      end
      CMD_SUNRISE, CMD_SUNSET: begin
        if (!running) begin
          for (ch = 0; ch < NUM_CH; ch++) begin
            if (c.op == CMD_SUNRISE) begin
              origin[ch] = '0;
              level[ch] = '0;
            end else begin
              origin[ch] = level[ch];
              goal[ch] = '0;
            end
          end
          running = 1'b1;
          rising = (c.op == CMD_SUNRISE);
          elapsed = '0;
          since_refresh = '0;
          refreshed = 1'b0;
          r.accepted = 1'b1;
        end
      end
      CMD_STOP: running = 1'b0;
      CMD_OFF: begin
        running = 1'b0;
        for (ch = 0; ch < NUM_CH; ch++) begin
          goal[ch] = '0;
          level[ch] = '0;
        end
      end
      default: ;
    endcase
    if (running) begin
      dur = 64'(rising ? rise_ms : fall_ms);
      r.remaining = (64'(elapsed) < dur) ? MS_W'(dur - 64'(elapsed)) : '0;
    end
    for (ch = 0; ch < NUM_CH; ch++) begin
      cap = 64'((full_scale[ch] > LEVEL_CAP) ? LEVEL_CAP : full_scale[ch]);
      r.pwm[ch] = (64'(level[ch]) > cap) ? LVL_W'(cap) : level[ch];
    end
    r.fading = running;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [MS_W-1:0] want,
                             input logic [MS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rgb_dawn_dusk_fader: FAIL");
      $finish;
    end
  end

  // Check the output transfer first, then predict the input transfer of this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (levels_due.size() == 0) begin
        $error("result with no expectation waiting");
        failed = 1'b1;
      end else begin
        due = levels_due.pop_front();
        check_field("pwm_white", MS_W'(due.pwm[CH_WHITE]), MS_W'(pwm_white_o));
        check_field("pwm_red", MS_W'(due.pwm[CH_RED]), MS_W'(pwm_red_o));
        check_field("pwm_blue", MS_W'(due.pwm[CH_BLUE]), MS_W'(pwm_blue_o));
        check_field("fading", MS_W'(due.fading), MS_W'(fading_o));
        check_field("accepted", MS_W'(due.accepted), MS_W'(accepted_o));
        check_field("finished", MS_W'(due.finished), MS_W'(finished_o));
        check_field("finished_sunrise", MS_W'(due.finished_sunrise),
                    MS_W'(finished_sunrise_o));
        check_field("remaining_ms", due.remaining, remaining_ms_o);
        outstanding--;
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      levels_due.push_back(step_fader('{cmd_i, white_pct_i, red_pct_i, blue_pct_i}));
  end

  // Sender: advance only after a transfer or while idle
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmds_pending.size() != 0) begin
        next_cmd = cmds_pending.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= next_cmd.op;
        white_pct_i <= next_cmd.white;
        red_pct_i <= next_cmd.red;
        blue_pct_i <= next_cmd.blue;
        if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall in short bursts
  always @(negedge clk_i) begin
    if (recv_hold != 0) begin
      out_stall_i <= 1'b1;
      recv_hold <= recv_hold - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      recv_hold <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [PCT_W-1:0] w = '0,
                           input logic [PCT_W-1:0] r = '0, input logic [PCT_W-1:0] b = '0);
    cmds_pending.push_back('{op, w, r, b});
    items_made++;
    outstanding++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_MAX_WHITE:  full_scale[CH_WHITE] = data[LVL_W-1:0];
      CFG_MAX_RED:    full_scale[CH_RED] = data[LVL_W-1:0];
      CFG_MAX_BLUE:   full_scale[CH_BLUE] = data[LVL_W-1:0];
      CFG_SUNRISE_MS: rise_ms = data[MS_W-1:0];
      CFG_SUNSET_MS:  fall_ms = data[MS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Hold until every queued item has produced its result
  task automatic settle();
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [PCT_W-1:0] rand_pct();
    if ($urandom_range(0, 3) == 0)
      return PCT_W'($urandom_range(PCT_MAX + 1, {PCT_W{1'b1}}));
    return PCT_W'($urandom_range(0, PCT_MAX));
  endfunction

  function automatic logic [CFG_W-1:0] pick_full();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_W'({LVL_W{1'b1}});
      2: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(1000, {LVL_W{1'b1}}));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_ms();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CFG_W'(1);
      2: return {CFG_W{1'b1}};
      3: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(2, 80));
    endcase
  endfunction

  function automatic int unsigned fade_ticks(input logic [MS_W-1:0] dur);
    if (dur > 200) return $urandom_range(3, 30);
    if ($urandom_range(0, 4) == 0) return 32'(dur / 2);
    return 32'(dur) + $urandom_range(10, 30);
  endfunction

  task automatic shuffle_regs();
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_WHITE, pick_full());
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_RED, pick_full());
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_BLUE, pick_full());
    if ($urandom_range(0, 2)) write_reg(CFG_SUNRISE_MS, pick_ms());
    if ($urandom_range(0, 2)) write_reg(CFG_SUNSET_MS, pick_ms());
    if ($urandom_range(0, 5) == 0)
      write_reg(3'($urandom_range(CFG_UNUSED_LO, {3{1'b1}})), CFG_W'($urandom()));
  endtask

  // One fade with random noise sprinkled between the ticks
  task automatic fade_run(input bit rise, input int unsigned ticks);
    queue_cmd(rise ? CMD_SUNRISE : CMD_SUNSET);
    repeat (ticks) begin
      if ($urandom_range(0, 11) == 0)
        queue_cmd(3'($urandom_range(0, {3{1'b1}})), rand_pct(), rand_pct(), rand_pct());
      queue_cmd(CMD_TICK);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle commands, clamping, refused starts, set levels and stop mid-fade
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_SET_LEVELS, PCT_MAX, PCT_MAX, PCT_MAX);
    queue_cmd(CMD_SET_LEVELS, {PCT_W{1'b1}}, '0, PCT_MAX + 7'd1);
    queue_cmd(CMD_UNKNOWN_LO, {PCT_W{1'b1}}, {PCT_W{1'b1}}, {PCT_W{1'b1}});
    queue_cmd({3{1'b1}});
    queue_cmd(CMD_STOP);
    queue_cmd(CMD_OFF);
    queue_cmd(CMD_SET_LEVELS, PCT_MAX, PCT_MAX, PCT_MAX);
    queue_cmd(CMD_SUNRISE);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_SUNRISE);
    queue_cmd(CMD_SUNSET);
    queue_cmd(CMD_SET_LEVELS, 7'd40, 7'd80, {PCT_W{1'b1}});
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_STOP);
    queue_cmd(CMD_SUNSET);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_OFF);
    settle();

    // Zero durations finish on the first tick
    write_reg(CFG_MAX_WHITE, CFG_W'({LVL_W{1'b1}}));
    write_reg(CFG_MAX_RED, CFG_W'({LVL_W{1'b1}}));
    write_reg(CFG_MAX_BLUE, CFG_W'({LVL_W{1'b1}}));
    write_reg(CFG_SUNRISE_MS, '0);
    write_reg(CFG_SUNSET_MS, '0);
    queue_cmd(CMD_SET_LEVELS, PCT_MAX, PCT_MAX, PCT_MAX);
    queue_cmd(CMD_SUNRISE);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_SUNSET);
    queue_cmd(CMD_TICK);
    settle();

    write_reg(CFG_MAX_WHITE, '0);
    write_reg(CFG_MAX_RED, '0);
    write_reg(CFG_MAX_BLUE, '0);
    write_reg(CFG_SUNRISE_MS, {CFG_W{1'b1}});
    queue_cmd(CMD_SET_LEVELS, PCT_MAX, PCT_MAX, PCT_MAX);
    queue_cmd(CMD_SUNRISE);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_OFF);
    settle();

    // Random: set levels, sunrise, sunset, with noise and register changes between runs
    while (items_made < ITEM_COUNT) begin
      calm = (items_made > ITEM_COUNT * 5 / 6) || ($urandom_range(0, 4) == 0);
      shuffle_regs();
      queue_cmd(CMD_SET_LEVELS, rand_pct(), rand_pct(), rand_pct());
      fade_run(1'b1, fade_ticks(rise_ms));
      if ($urandom_range(0, 2) == 0)
        queue_cmd(CMD_SET_LEVELS, rand_pct(), rand_pct(), rand_pct());
      fade_run(1'b0, fade_ticks(fall_ms));
      if ($urandom_range(0, 1)) queue_cmd(CMD_STOP);
      settle();
    end

    repeat (60) @(negedge clk_i);
    if (!failed) begin
      $display("tb_rgb_dawn_dusk_fader: PASS");
    end else begin
      $display("tb_rgb_dawn_dusk_fader: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rddf_pkg.sv
rtl/rddf_ctrl.sv
rtl/rddf_dp.sv
rtl/rgb_dawn_dusk_fader.sv
verif/tb_rgb_dawn_dusk_fader.sv
